### rtl/core/tls_pkg.sv
// Package for the temperature logging sequencer: word types, codes and fixed constants.
// Used by tls_ctrl, tls_datapath and temperature_logger_sequencer_core.
package tls_pkg;

   localparam int HEADER_BYTES = 22;
   localparam int STORE_DEPTH  = 20;
   localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
   localparam int HDR_IDX_W    = 5;

   localparam logic [7:0]  CMD_LEN     = 8'd31;
   localparam logic [7:0]  HEADER_TAG  = 8'h01;
   localparam logic [7:0]  HEADER_LEN  = 8'(HEADER_BYTES);
   localparam logic [15:0] HEADER_BASE = 16'(HEADER_BYTES);
   localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 2);

   localparam logic [7:0] CHAR_B    = 8'h42;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_L    = 8'h4C;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam int ERR_OVERFLOW = 0;
   localparam int ERR_LENGTH   = 1;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_LOG  = 2'd1,
      MODE_HOLD = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_WORD   = 2'd1,
      KIND_REPORT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_HDR  = 2'd2,
      ST_RPT  = 2'd3
   } state_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  rx_byte;
      logic        end_of_command;
      logic [15:0] sample;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [15:0] wdata;
      logic        accepted;
      mode_type    mode_now;
      logic [1:0]  error_bits;
      logic        final_res;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic take;
      logic exec;
      logic hdr_load;
      logic rpt_load;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic is_cmd;
      logic is_end;
      logic start_ok;
      logic slot_free;
      logic hdr_last;
   } stat_type;

endpackage

### rtl/core/temperature_logger_sequencer_core.sv
// Top level of the temperature logging sequencer.
// Depends on tls_pkg, tls_ctrl and tls_datapath.
//
// Usage:
//  - req_ channel: one word per event. cmd=0 is an eight-second tick with a
//    sample; cmd=1 is one received command byte, end_of_command on the last.
//  - rsp_ channel: log memory writes (byte or word) and one report per
//    finished command window; final_res marks the last word of an input.
//  - Timing: an input word is taken in IDLE and executed in EXEC, which also
//    loads a tick's log write into the output register; req_ready rises again
//    once the controller is back in IDLE. A window end adds its report from
//    RPT after EXEC. A valid start command emits 21 header writes plus the
//    report, one per cycle while the output register is free, and holds the
//    input until the report is loaded. Stalls on rsp_ready delay each step.
//  - Stall: while rsp_ready is low a finished word waits in the output
//    register; the controller holds execution and header emission until the
//    register frees, and nothing is dropped. req_ready stays low meanwhile
//    except in IDLE, where the next input word is still taken.
//  - Reset: synchronous, active high. Status returns to idle, counters,
//    pointers and sticky errors clear; the receive store is not cleared.
module temperature_logger_sequencer_core #(
   parameter int RX_DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tls_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tls_pkg::rsp_type  rsp_data
);

   tls_pkg::ctl_type  command;
   tls_pkg::stat_type status;

   // sequence each input word: execute, then header burst and report if needed
   tls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .command   (command)
   );

   // hold logging state, receive store and the output register
   tls_datapath #(
      .RX_DEPTH (RX_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .command   (command),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // one word in flight: ready drops right after a word is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken while previous word still executing");

   // accepted only appears on a report, which then shows logging status
   a_accept_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.accepted) |->
         (rsp_data.kind == tls_pkg::KIND_REPORT && rsp_data.mode_now == tls_pkg::MODE_LOG))
      else $error("accepted flag outside a logging report");

   // byte writes only come from the header burst, which a report always follows
   a_byte_not_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == tls_pkg::KIND_BYTE) |-> !rsp_data.final_res)
      else $error("byte write marked as last word");

   // a final word write (a logged sample) never lands inside the header area
   a_word_above_hdr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == tls_pkg::KIND_WORD && rsp_data.final_res) |->
         (rsp_data.address >= tls_pkg::HEADER_BASE))
      else $error("sample write below header");

endmodule

### rtl/core/tls_ctrl.sv
// Controller state machine of the logging sequencer.
// Depends on tls_pkg for the state, command and status types.
module tls_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tls_pkg::stat_type  status,
   output tls_pkg::ctl_type   command
);

   tls_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tls_pkg::ST_IDLE: begin
            if (req_valid) state_in = tls_pkg::ST_EXEC;
         end
         tls_pkg::ST_EXEC: begin
            if (status.slot_free) begin
               if (!status.is_cmd || !status.is_end) state_in = tls_pkg::ST_IDLE;
               else if (status.start_ok)            state_in = tls_pkg::ST_HDR;
               else                                 state_in = tls_pkg::ST_RPT;
            end
         end
         tls_pkg::ST_HDR: begin
            if (status.slot_free && status.hdr_last) state_in = tls_pkg::ST_RPT;
         end
         tls_pkg::ST_RPT: begin
            if (status.slot_free) state_in = tls_pkg::ST_IDLE;
         end
         default: state_in = tls_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready        = 1'b0;
      command          = '0;
      unique case (state_ff)
         tls_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            command.take = req_valid;
         end
         tls_pkg::ST_EXEC: command.exec     = status.slot_free;
         tls_pkg::ST_HDR:  command.hdr_load = status.slot_free;
         tls_pkg::ST_RPT:  command.rpt_load = status.slot_free;
         default: ;
      endcase
   end

endmodule

### rtl/core/tls_datapath.sv
// Datapath of the logging sequencer: logging state, receive store, output register.
// Depends on tls_pkg; driven by commands from tls_ctrl.
module tls_datapath #(
   parameter int RX_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  tls_pkg::req_type   req_data,
   input  tls_pkg::ctl_type   command,
   output tls_pkg::stat_type  status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tls_pkg::rsp_type   rsp_data
);

   localparam logic [7:0] RxDepth    = 8'(RX_DEPTH);
   localparam logic [7:0] StoreDepth = 8'(tls_pkg::STORE_DEPTH);

   tls_pkg::req_type  req_ff;
   tls_pkg::mode_type mode_ff, mode_in;
   logic [15:0] delay_ff, delay_in;
   logic [15:0] interval_ff, interval_in;
   logic [15:0] tick_ff, tick_in;
   logic [15:0] wp_ff, wp_in;
   logic [7:0]  rx_count_ff, rx_count_in;
   logic [1:0]  err_ff, err_in;
   logic        good_ff, good_in;
   logic        acc_ff, acc_in;
   logic [7:0]  rx_store_ff [tls_pkg::STORE_DEPTH];
   logic [tls_pkg::HDR_IDX_W-1:0] hdr_idx_ff, hdr_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   tls_pkg::rsp_type rsp_ff, rsp_in;

   logic        byte_kept, store_we, tick_emit, start_ok;
   logic [7:0]  count_next;
   logic [15:0] tick_inc;
   logic [tls_pkg::STORE_IDX_W-1:0] hdr_rd_idx;
   logic [7:0]  b;

   assign b          = req_ff.rx_byte;
   assign byte_kept  = rx_count_ff < RxDepth;
   assign count_next = byte_kept ? rx_count_ff + 8'd1 : rx_count_ff;
   assign store_we   = command.exec && req_ff.cmd && byte_kept && (rx_count_ff < StoreDepth);
   assign tick_inc   = tick_ff + 16'd1;
   assign tick_emit  = (mode_ff == tls_pkg::MODE_LOG) && (delay_ff == 16'd0)
                       && (tick_inc >= interval_ff) && (wp_ff >= tls_pkg::HEADER_BASE);
   // bytes 0..19 were all written in a full-length window, so the running check is complete
   assign start_ok   = req_ff.cmd && req_ff.end_of_command && (count_next == tls_pkg::CMD_LEN)
                       && (mode_ff == tls_pkg::MODE_IDLE) && good_ff;
   assign hdr_rd_idx = tls_pkg::STORE_IDX_W'(hdr_idx_ff - tls_pkg::HDR_IDX_W'(2));

   assign status.is_cmd    = req_ff.cmd;
   assign status.is_end    = req_ff.end_of_command;
   assign status.start_ok  = start_ok;
   assign status.slot_free = !rsp_valid_ff || rsp_ready;
   assign status.hdr_last  = hdr_idx_ff == tls_pkg::HDR_LAST;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // running start-command check, one stored byte at a time
   always_comb begin
      good_in = good_ff;
      if (store_we) begin
         if (rx_count_ff == 8'd0) begin
            good_in = b == tls_pkg::CHAR_B;
         end else if (rx_count_ff <= 8'd14) begin
            good_in = good_ff && (b >= tls_pkg::CHAR_ZERO) && (b <= tls_pkg::CHAR_NINE);
         end else if (rx_count_ff == 8'd19) begin
            good_in = good_ff && ((b == tls_pkg::CHAR_A) || (b == tls_pkg::CHAR_L));
         end
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      delay_in    = delay_ff;
      interval_in = interval_ff;
      tick_in     = tick_ff;
      wp_in       = wp_ff;
      rx_count_in = rx_count_ff;
      err_in      = err_ff;
      acc_in      = acc_ff;
      hdr_idx_in  = hdr_idx_ff;
      if (command.exec && !req_ff.cmd) begin
         tick_in = tick_inc;
         if (mode_ff == tls_pkg::MODE_LOG) begin
            if (delay_ff != 16'd0) begin
               delay_in = delay_ff - 16'd1;
               tick_in  = '0;
            end else if (tick_inc < interval_ff) begin
               tick_in = tick_inc;
            end else if (wp_ff < tls_pkg::HEADER_BASE) begin
               mode_in = tls_pkg::MODE_HOLD;
            end else begin
               wp_in   = wp_ff + 16'd2;
               tick_in = '0;
            end
         end
      end
      if (command.exec && req_ff.cmd) begin
         rx_count_in = count_next;
         if (!byte_kept) err_in[tls_pkg::ERR_OVERFLOW] = 1'b1;
         acc_in     = 1'b0;
         hdr_idx_in = '0;
         if (req_ff.end_of_command) begin
            if (count_next != tls_pkg::CMD_LEN) err_in[tls_pkg::ERR_LENGTH] = 1'b1;
            if (start_ok) begin
               acc_in      = 1'b1;
               delay_in    = {rx_store_ff[15], rx_store_ff[16]};
               interval_in = {rx_store_ff[17], rx_store_ff[18]};
               wp_in       = tls_pkg::HEADER_BASE;
               tick_in     = '0;
               mode_in     = tls_pkg::MODE_LOG;
            end
         end
      end
      if (command.hdr_load) hdr_idx_in = hdr_idx_ff + tls_pkg::HDR_IDX_W'(1);
      if (command.rpt_load) rx_count_in = '0;
   end

   // output word assembly; every word reflects state already updated by this item
   always_comb begin
      rsp_in            = rsp_ff;
      rsp_in.mode_now   = mode_in;
      rsp_in.error_bits = err_in;
      rsp_in.accepted   = 1'b0;
      rsp_in.final_res  = 1'b0;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      priority if (command.exec && !req_ff.cmd && tick_emit) begin
         rsp_valid_in     = 1'b1;
         rsp_in.kind      = tls_pkg::KIND_WORD;
         rsp_in.address   = wp_ff;
         rsp_in.wdata     = req_ff.sample;
         rsp_in.final_res = 1'b1;
      end else if (command.hdr_load) begin
         rsp_valid_in = 1'b1;
         priority if (hdr_idx_ff == tls_pkg::HDR_IDX_W'(0)) begin
            rsp_in.kind    = tls_pkg::KIND_BYTE;
            rsp_in.address = 16'd0;
            rsp_in.wdata   = {8'd0, tls_pkg::HEADER_TAG};
         end else if (hdr_idx_ff == tls_pkg::HDR_IDX_W'(1)) begin
            rsp_in.kind    = tls_pkg::KIND_BYTE;
            rsp_in.address = 16'd1;
            rsp_in.wdata   = {8'd0, tls_pkg::HEADER_LEN};
         end else if (hdr_idx_ff == tls_pkg::HDR_IDX_W'(2)) begin
            rsp_in.kind    = tls_pkg::KIND_WORD;
            rsp_in.address = 16'd2;
            rsp_in.wdata   = 16'd0;
         end else begin
            rsp_in.kind    = tls_pkg::KIND_BYTE;
            rsp_in.address = 16'(hdr_idx_ff) + 16'd1;
            rsp_in.wdata   = {8'd0, rx_store_ff[hdr_rd_idx]};
         end
      end else if (command.rpt_load) begin
         rsp_valid_in     = 1'b1;
         rsp_in.kind      = tls_pkg::KIND_REPORT;
         rsp_in.address   = 16'd0;
         rsp_in.wdata     = {8'd0, rx_count_ff};
         rsp_in.accepted  = acc_ff;
         rsp_in.final_res = 1'b1;
      end else begin
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= tls_pkg::MODE_IDLE;
         delay_ff     <= '0;
         interval_ff  <= '0;
         tick_ff      <= '0;
         wp_ff        <= '0;
         rx_count_ff  <= '0;
         err_ff       <= '0;
         good_ff      <= 1'b0;
         acc_ff       <= 1'b0;
         hdr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         delay_ff     <= delay_in;
         interval_ff  <= interval_in;
         tick_ff      <= tick_in;
         wp_ff        <= wp_in;
         rx_count_ff  <= rx_count_in;
         err_ff       <= err_in;
         good_ff      <= good_in;
         acc_ff       <= acc_in;
         hdr_idx_ff   <= hdr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (command.take) req_ff <= req_data;
      if (store_we) rx_store_ff[rx_count_ff[tls_pkg::STORE_IDX_W-1:0]] <= b;
   end

endmodule

### bench/tb_temperature_logger_sequencer_core.sv
`timescale 1ns / 100ps
// Self-checking bench for temperature_logger_sequencer_core: command windows, ticks,
// header bursts, receive overflow, and stalls on both channels.
// Depends on tls_pkg and the core RTL only.
module tb_temperature_logger_sequencer_core;

   localparam int RX_DEPTH     = 128;
   localparam int MAX_REPORTED = 10;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int SETTLE       = 50;
   localparam int LONG_HOLD    = 400;

   typedef logic [7:0] byte_list_type [$];

   // ways a start frame is spoiled in idle
   typedef enum int {
      BAD_LEAD,
      BAD_DIGIT,
      BAD_TAG
   } flaw_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   tls_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   tls_pkg::rsp_type rsp_data;

   temperature_logger_sequencer_core #(
      .RX_DEPTH(RX_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Own copy of the logger state, advanced once per accepted input word.
   tls_pkg::mode_type status       = tls_pkg::MODE_IDLE;
   logic [15:0]       start_delay  = '0;
   logic [15:0]       interval_len = '0;
   logic [15:0]       tick_ctr     = '0;
   logic [15:0]       log_addr     = '0;
   logic [7:0]        rx_len       = '0;
   logic [7:0]        rx_keep [tls_pkg::STORE_DEPTH] = '{default: 8'h00};
   logic [1:0]        err_flags    = '0;

   // Log writes and reports still owed by the block, oldest first.
   tls_pkg::rsp_type log_words_due [$];

   int               mismatches = 0;
   tls_pkg::rsp_type want;

   // Sender pacing: bursts of back-to-back words, random gaps between them.
   int burst_left = 0;
   int max_gap    = 6;

   // Receiver pacing: a rotating stall pattern plus an on-demand long hold-off.
   int         hold_requests = 0;
   int         hold_served   = 0;
   int         hold_left     = 0;
   logic [8:0] pat_phase     = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Append one expected word, stamped with the status and flags as they stand now.
   function automatic void queue_word(input tls_pkg::kind_type k, input logic [15:0] addr,
                                      input logic [15:0] data, input logic acc);
      tls_pkg::rsp_type r;
      r.kind       = k;
      r.address    = addr;
      r.wdata      = data;
      r.accepted   = acc;
      r.mode_now   = status;
      r.error_bits = err_flags;
      r.final_res  = 1'b0;
      log_words_due.push_back(r);
   endfunction

   // Advance the logger by one input word and queue every word it causes.
   function automatic void advance_logger(input tls_pkg::req_type w);
      int               first;
      int               i;
      logic             take;
      tls_pkg::rsp_type r;
      first = log_words_due.size();
      take  = 1'b0;
      if (!w.cmd) begin
         // tick: count, then run down the start delay or log at the interval
         tick_ctr++;
         if (status == tls_pkg::MODE_LOG) begin
            if (start_delay != 16'd0) begin
               start_delay--;
               tick_ctr = '0;
            end else if (tick_ctr >= interval_len) begin
               if (log_addr < tls_pkg::HEADER_BASE) begin
                  // address wrapped under the header: hold, write nothing
                  status = tls_pkg::MODE_HOLD;
               end else begin
                  queue_word(tls_pkg::KIND_WORD, log_addr, w.sample, 1'b0);
                  log_addr += 16'd2;
                  tick_ctr = '0;
               end
            end
         end
      end else begin
         // command byte: count it while there is room, flag overflow past that
         if (rx_len < RX_DEPTH) begin
            if (rx_len < tls_pkg::STORE_DEPTH)
               rx_keep[rx_len[tls_pkg::STORE_IDX_W-1:0]] = w.rx_byte;
            rx_len++;
         end else begin
            err_flags[tls_pkg::ERR_OVERFLOW] = 1'b1;
         end
         if (w.end_of_command) begin
            if (rx_len != tls_pkg::CMD_LEN) begin
               err_flags[tls_pkg::ERR_LENGTH] = 1'b1;
            end else begin
               take = (status == tls_pkg::MODE_IDLE) && (rx_keep[0] == tls_pkg::CHAR_B) &&
                      (rx_keep[19] == tls_pkg::CHAR_A || rx_keep[19] == tls_pkg::CHAR_L);
               for (i = 1; i < 15; i++)
                  if (rx_keep[i] < tls_pkg::CHAR_ZERO || rx_keep[i] > tls_pkg::CHAR_NINE)
                     take = 1'b0;
               if (take) begin
                  start_delay  = {rx_keep[15], rx_keep[16]};
                  interval_len = {rx_keep[17], rx_keep[18]};
                  log_addr     = tls_pkg::HEADER_BASE;
                  tick_ctr     = '0;
                  status       = tls_pkg::MODE_LOG;
                  // header: tag, length, blank word, then command bytes 1 to 18
                  queue_word(tls_pkg::KIND_BYTE, 16'd0, {8'h00, tls_pkg::HEADER_TAG}, 1'b0);
                  queue_word(tls_pkg::KIND_BYTE, 16'd1, {8'h00, tls_pkg::HEADER_LEN}, 1'b0);
                  queue_word(tls_pkg::KIND_WORD, 16'd2, 16'h0000, 1'b0);
                  for (i = 1; i <= 18; i++)
                     queue_word(tls_pkg::KIND_BYTE, 16'(i + 3), {8'h00, rx_keep[i]}, 1'b0);
               end
            end
            queue_word(tls_pkg::KIND_REPORT, 16'd0, {8'h00, rx_len}, take);
            rx_len = '0;
         end
      end
      // mark the last word this input caused
      if (log_words_due.size() > first) begin
         r = log_words_due[log_words_due.size() - 1];
         r.final_res = 1'b1;
         log_words_due[log_words_due.size() - 1] = r;
      end
   endfunction

   // Random word; cmd_pct is the share of command bytes in percent.
   function automatic tls_pkg::req_type random_word(input int cmd_pct);
      tls_pkg::req_type w;
      w.cmd            = ($urandom_range(0, 99) < cmd_pct);
      w.rx_byte        = 8'($urandom_range(0, 255));
      w.end_of_command = w.cmd ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1));
      w.sample         = 16'($urandom_range(0, 65535));
      return w;
   endfunction

   // Well-formed 31-byte start frame with random digits and trailing bytes.
   function automatic byte_list_type start_frame(input logic [15:0] delay,
                                                 input logic [15:0] every,
                                                 input logic [7:0] tag);
      byte_list_type f;
      f.push_back(tls_pkg::CHAR_B);
      repeat (14) f.push_back(8'($urandom_range(tls_pkg::CHAR_ZERO, tls_pkg::CHAR_NINE)));
      f.push_back(delay[15:8]);
      f.push_back(delay[7:0]);
      f.push_back(every[15:8]);
      f.push_back(every[7:0]);
      f.push_back(tag);
      while (f.size() < tls_pkg::CMD_LEN)
         f.push_back(8'($urandom_range(0, 255)));
      return f;
   endfunction

   // Offer one word and hold it until taken; open a new burst with a gap when due.
   task automatic send_word(input tls_pkg::req_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      advance_logger(w);
   endtask

   task automatic send_tick(input logic [15:0] sample);
      tls_pkg::req_type w;
      w = random_word(0);
      w.sample = sample;
      send_word(w);
   endtask

   // Send a whole command window, end marker on its last byte.
   task automatic send_window(input byte_list_type frame);
      tls_pkg::req_type w;
      foreach (frame[i]) begin
         w = random_word(100);
         w.rx_byte        = frame[i];
         w.end_of_command = (i == frame.size() - 1);
         send_word(w);
      end
   endtask

   // Drop valid and wait until every owed word has come out.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (log_words_due.size() != 0);
   endtask

   // Ticks in idle are counted only; short windows raise the length flag.
   task automatic test_idle_traffic();
      byte_list_type f;
      send_tick(16'h0000);
      send_tick(16'hFFFF);
      f = {tls_pkg::CHAR_B};
      send_window(f);
      f = {8'hFF, 8'h00};
      send_window(f);
   endtask

   // Overflowing window, then a start frame spoiled one way: it may not start.
   task automatic test_rejected_starts();
      byte_list_type f;
      int            pos;
      logic [7:0]    b;
      flaw_type      flaw;
      repeat (RX_DEPTH + 1)
         f.push_back(8'($urandom_range(0, 255)));
      send_window(f);
      f = start_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      $urandom_range(0, 1) ? tls_pkg::CHAR_A : tls_pkg::CHAR_L);
      flaw = flaw_type'($urandom_range(0, 2));
      case (flaw)
         BAD_LEAD: begin
            b = 8'($urandom_range(0, 255));
            if (b == tls_pkg::CHAR_B)
               b = ~b;
            f[0] = b;
         end
         BAD_DIGIT: begin
            // just outside the digit range on either side
            pos = $urandom_range(1, 14);
            f[pos] = $urandom_range(0, 1) ? tls_pkg::CHAR_ZERO - 8'd1
                                          : tls_pkg::CHAR_NINE + 8'd1;
         end
         BAD_TAG: begin
            b = 8'($urandom_range(0, 255));
            if (b == tls_pkg::CHAR_A || b == tls_pkg::CHAR_L)
               b = 8'h00;
            f[19] = b;
         end
         default: ;
      endcase
      send_window(f);
   endtask

   // Accepted start with a short delay and interval, then extreme samples.
   task automatic test_start_logging();
      byte_list_type f;
      f = start_frame({8'h00, 8'($urandom_range(0, 3))}, {8'h00, 8'($urandom_range(0, 2))},
                      $urandom_range(0, 1) ? tls_pkg::CHAR_A : tls_pkg::CHAR_L);
      send_window(f);
      // pairs of all-zero and all-one samples so both land on a logging tick
      for (int k = 0; k < 8; k++)
         send_tick(k[1] ? 16'hFFFF : 16'h0000);
      drain_results();
   endtask

   // Hold the result side off for a long stretch while words keep coming.
   task automatic test_output_backpressure();
      hold_requests++;
      max_gap = 0;
      repeat (10) send_word(random_word(20));
      max_gap = 6;
   endtask

   // Result side: rotate through always-ready, sparse, periodic and coin-flip stalls.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         pat_phase = pat_phase + 9'd1;
         case (pat_phase[8:7])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ready <= (pat_phase[2:0] != 3'd5);
            default: rsp_ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // Compare each taken word with the oldest one owed, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (log_words_due.size() == 0) begin
            if (mismatches < MAX_REPORTED)
               $display("unexpected word: kind=%0d addr=%h data=%h acc=%0b mode=%0d err=%b",
                        rsp_data.kind, rsp_data.address, rsp_data.wdata,
                        rsp_data.accepted, rsp_data.mode_now, rsp_data.error_bits);
            mismatches++;
         end else begin
            want = log_words_due.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.address !== want.address ||
                rsp_data.wdata !== want.wdata || rsp_data.accepted !== want.accepted ||
                rsp_data.mode_now !== want.mode_now ||
                rsp_data.error_bits !== want.error_bits ||
                rsp_data.final_res !== want.final_res) begin
               if (mismatches < MAX_REPORTED) begin
                  $display("mismatch: expected kind=%0d addr=%h data=%h acc=%0b mode=%0d err=%b last=%0b",
                           want.kind, want.address, want.wdata, want.accepted,
                           want.mode_now, want.error_bits, want.final_res);
                  $display("          got      kind=%0d addr=%h data=%h acc=%0b mode=%0d err=%b last=%0b",
                           rsp_data.kind, rsp_data.address, rsp_data.wdata,
                           rsp_data.accepted, rsp_data.mode_now, rsp_data.error_bits,
                           rsp_data.final_res);
               end
               mismatches++;
            end
         end
      end
   end

   initial begin
      int waited;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_idle_traffic();
      test_rejected_starts();
      test_start_logging();
      test_output_backpressure();
      req_valid <= 1'b0;
      // wait out the owed words, then let the block settle
      waited = 0;
      while (log_words_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && log_words_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog: the slowest correct run is far below this.
   initial begin
      #12_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
